[rtl/frame_buffer_ownership_tracker_macros.svh]
// ----------------------------------------------------------------------------
// Frame buffer ownership tracker assertion macros
// Shared property wrappers, clocked on clk_i and quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FRAME_BUFFER_OWNERSHIP_TRACKER_MACROS_SVH
`define FRAME_BUFFER_OWNERSHIP_TRACKER_MACROS_SVH

// Same-cycle implication.
`define FBOT_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fbot: same-cycle check failed");

// Next-cycle implication.
`define FBOT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fbot: next-cycle check failed");

`endif

[rtl/fbot_pkg.sv]
// ----------------------------------------------------------------------------
// Frame buffer ownership tracker package
// Command, status, event and ownership codes plus the word structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbot_pkg;

  localparam int BufferCountDef = 2;
  localparam int SlotFieldW     = 3;
  localparam int CounterW       = 32;
  localparam int ApbDataW       = 32;
  localparam int ApbAddrW       = 2;

  typedef enum logic [2:0] {
    CMD_CAPTURE_NEXT = 3'd0,
    CMD_FRAME_DONE   = 3'd1,
    CMD_OVERRUN      = 3'd2,
    CMD_ENGINE_ERROR = 3'd3,
    CMD_STOP         = 3'd4,
    CMD_ACQUIRE      = 3'd5,
    CMD_RELEASE      = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BUSY     = 3'd1,
    ST_NOT_INIT = 3'd2,
    ST_PARAM    = 3'd3,
    ST_ENGINE   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_READY   = 2'd1,
    EV_OVERRUN = 2'd2,
    EV_ERROR   = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    OWN_FREE      = 2'd0,
    OWN_CAPTURING = 2'd1,
    OWN_READY     = 2'd2,
    OWN_IN_USE    = 2'd3
  } owner_e;

  // Register index of the configuration port.
  typedef enum logic [0:0] {
    REG_ENABLED = 1'b0
  } reg_e;

  typedef struct packed {
    cmd_e                  command;
    logic [SlotFieldW-1:0] release_slot;
    logic                  release_null;
    logic                  engine_stop_ok;
    logic                  engine_start_ok;
  } item_t;

  typedef struct packed {
    status_e               status;
    event_e                event_res;
    logic [SlotFieldW-1:0] slot;
    logic                  slot_valid;
    logic                  stop_issued;
    logic                  overrun_inc;
    logic                  error_inc;
  } result_t;

endpackage

[rtl/frame_buffer_ownership_tracker.sv]
// ----------------------------------------------------------------------------
// Frame buffer ownership tracker
// Ping-pong style owner bookkeeping for a small set of capture frame buffers.
// ----------------------------------------------------------------------------
// Usage: busy_o stays low, so a command word is taken at every rising edge
// with start_i high, one per clock. Its result word passes through the input
// register and then the result register, and appears on the result ports
// flagged by done_o. There is no way to hold a result off: the receiver must
// capture every word in the cycle that done_o is high. The one-per-clock rate
// comes from the combinational read-modify-write of the buffer ownership
// registers. Write the enabled register over the APB port only while no
// command is in flight.
`timescale 1ns / 1ps
`include "frame_buffer_ownership_tracker_macros.svh"

module frame_buffer_ownership_tracker #(
  parameter int BUFFER_COUNT = fbot_pkg::BufferCountDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Command channel
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [2:0]                          command_i,
  input  logic [fbot_pkg::SlotFieldW-1:0]     release_slot_i,
  input  logic                                release_null_i,
  input  logic                                engine_stop_ok_i,
  input  logic                                engine_start_ok_i,
  // Result channel
  output logic                                done_o,
  output logic [2:0]                          status_o,
  output logic [1:0]                          event_res_o,
  output logic [fbot_pkg::SlotFieldW-1:0]     slot_o,
  output logic                                slot_valid_o,
  output logic                                stop_issued_o,
  output logic [fbot_pkg::CounterW-1:0]       overrun_total_o,
  output logic [fbot_pkg::CounterW-1:0]       error_total_o,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fbot_pkg::ApbAddrW-1:0]       paddr,
  input  logic [fbot_pkg::ApbDataW-1:0]       pwdata,
  output logic [fbot_pkg::ApbDataW-1:0]       prdata,
  output logic                                pready
);

  localparam int SlotW = $clog2(BUFFER_COUNT);

  // Input register
  fbot_pkg::item_t   item_q;
  logic              item_vld_q;

  // Ownership state
  fbot_pkg::owner_e  owner_q [BUFFER_COUNT];
  fbot_pkg::owner_e  owner_d [BUFFER_COUNT];
  logic              cap_vld_q, cap_vld_d;
  logic [SlotW-1:0]  cap_idx_q, cap_idx_d;
  logic              rdy_vld_q, rdy_vld_d;
  logic [SlotW-1:0]  rdy_idx_q, rdy_idx_d;
  logic              stop_pend_q, stop_pend_d;
  logic [fbot_pkg::CounterW-1:0] ovr_cnt_q;
  logic [fbot_pkg::CounterW-1:0] err_cnt_q;

  // Result register
  fbot_pkg::result_t result_d;
  fbot_pkg::result_t result_q;
  logic              done_q;

  logic              enabled_q;
  logic              cfg_wr;
  fbot_pkg::reg_e    cfg_reg;

  // Never stall: one command per clock.
  assign busy_o = 1'b0;

  // --------------------------------------------------------------------------
  // Configuration port. A single register, so every address maps onto it.
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_reg = fbot_pkg::REG_ENABLED;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        fbot_pkg::REG_ENABLED: enabled_q <= pwdata[0];
        default:               enabled_q <= enabled_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_reg)
      fbot_pkg::REG_ENABLED: prdata = {{(fbot_pkg::ApbDataW - 1){1'b0}}, enabled_q};
      default:               prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register: capture the command word on acceptance.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      item_q.command         <= fbot_pkg::cmd_e'(command_i);
      item_q.release_slot    <= release_slot_i;
      item_q.release_null    <= release_null_i;
      item_q.engine_stop_ok  <= engine_stop_ok_i;
      item_q.engine_start_ok <= engine_start_ok_i;
    end
  end

  // --------------------------------------------------------------------------
  // Single-pass command evaluation against the ownership state.
  // --------------------------------------------------------------------------
  fbot_cmd #(
    .BUFFER_COUNT (BUFFER_COUNT)
  ) u_cmd (
    .item_i      (item_q),
    .enabled_i   (enabled_q),
    .owner_i     (owner_q),
    .cap_vld_i   (cap_vld_q),
    .cap_idx_i   (cap_idx_q),
    .rdy_vld_i   (rdy_vld_q),
    .rdy_idx_i   (rdy_idx_q),
    .stop_pend_i (stop_pend_q),
    .owner_o     (owner_d),
    .cap_vld_o   (cap_vld_d),
    .cap_idx_o   (cap_idx_d),
    .rdy_vld_o   (rdy_vld_d),
    .rdy_idx_o   (rdy_idx_d),
    .stop_pend_o (stop_pend_d),
    .result_o    (result_d)
  );

  // Commit state and counters only when a command word is in the input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUFFER_COUNT; i++) begin
        owner_q[i] <= fbot_pkg::OWN_FREE;
      end
      cap_vld_q   <= 1'b0;
      cap_idx_q   <= '0;
      rdy_vld_q   <= 1'b0;
      rdy_idx_q   <= '0;
      stop_pend_q <= 1'b0;
      ovr_cnt_q   <= '0;
      err_cnt_q   <= '0;
    end else if (item_vld_q) begin
      owner_q     <= owner_d;
      cap_vld_q   <= cap_vld_d;
      cap_idx_q   <= cap_idx_d;
      rdy_vld_q   <= rdy_vld_d;
      rdy_idx_q   <= rdy_idx_d;
      stop_pend_q <= stop_pend_d;
      if (result_d.overrun_inc) begin
        ovr_cnt_q <= ovr_cnt_q + 1'b1;
      end
      if (result_d.error_inc) begin
        err_cnt_q <= err_cnt_q + 1'b1;
      end
    end
  end

  // Result register: one-cycle strobe, payload held without reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_vld_q) begin
      result_q <= result_d;
    end
  end

  assign done_o        = done_q;
  assign status_o      = result_q.status;
  assign event_res_o   = result_q.event_res;
  assign slot_o        = result_q.slot;
  assign slot_valid_o  = result_q.slot_valid;
  assign stop_issued_o = result_q.stop_issued;
  // Counters commit on the same edge as the result, so they show the
  // post-command totals while done_o is high.
  assign overrun_total_o = ovr_cnt_q;
  assign error_total_o   = err_cnt_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `FBOT_ASSERT_NEXT(a_item_gives_result, item_vld_q, done_q)
  `FBOT_ASSERT_IMPLIES(a_result_has_item, done_q, $past(item_vld_q))
  `FBOT_ASSERT_IMPLIES(a_cap_buffer_owned, cap_vld_q, owner_q[cap_idx_q] == fbot_pkg::OWN_CAPTURING)
  `FBOT_ASSERT_IMPLIES(a_slot_only_on_ok, done_q && result_q.slot_valid, result_q.status == fbot_pkg::ST_OK)
  `FBOT_ASSERT_IMPLIES(a_ovr_cnt_on_event, ovr_cnt_q != $past(ovr_cnt_q), done_q && result_q.event_res == fbot_pkg::EV_OVERRUN)

endmodule

[rtl/fbot_cmd.sv]
// ----------------------------------------------------------------------------
// Frame buffer ownership tracker command logic
// Evaluates one command against the current ownership state in one pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbot_cmd #(
  parameter int BUFFER_COUNT = fbot_pkg::BufferCountDef,
  localparam int SlotW       = $clog2(BUFFER_COUNT)
) (
  input  fbot_pkg::item_t    item_i,
  input  logic               enabled_i,
  input  fbot_pkg::owner_e   owner_i [BUFFER_COUNT],
  input  logic               cap_vld_i,
  input  logic [SlotW-1:0]   cap_idx_i,
  input  logic               rdy_vld_i,
  input  logic [SlotW-1:0]   rdy_idx_i,
  input  logic               stop_pend_i,
  output fbot_pkg::owner_e   owner_o [BUFFER_COUNT],
  output logic               cap_vld_o,
  output logic [SlotW-1:0]   cap_idx_o,
  output logic               rdy_vld_o,
  output logic [SlotW-1:0]   rdy_idx_o,
  output logic               stop_pend_o,
  output fbot_pkg::result_t  result_o
);

  localparam logic [fbot_pkg::SlotFieldW:0] RelLimit = (fbot_pkg::SlotFieldW + 1)'(BUFFER_COUNT);

  logic             free_found;
  logic [SlotW-1:0] pick;
  logic [SlotW-1:0] rel_idx;
  logic             rel_in_range;

  // Lowest free buffer: scan downward so the lowest index wins.
  always_comb begin
    free_found = 1'b0;
    pick       = '0;
    for (int i = BUFFER_COUNT - 1; i >= 0; i--) begin
      if (owner_i[i] == fbot_pkg::OWN_FREE) begin
        free_found = 1'b1;
        pick       = SlotW'(i);
      end
    end
  end

  assign rel_in_range = ({1'b0, item_i.release_slot} < RelLimit);
  assign rel_idx      = item_i.release_slot[SlotW-1:0];

  always_comb begin
    owner_o     = owner_i;
    cap_vld_o   = cap_vld_i;
    cap_idx_o   = cap_idx_i;
    rdy_vld_o   = rdy_vld_i;
    rdy_idx_o   = rdy_idx_i;
    stop_pend_o = stop_pend_i;
    result_o    = '{status: fbot_pkg::ST_OK, event_res: fbot_pkg::EV_NONE, default: '0};

    unique case (item_i.command)
      fbot_pkg::CMD_CAPTURE_NEXT: begin
        if (!enabled_i) begin
          result_o.status = fbot_pkg::ST_NOT_INIT;
        end else if (cap_vld_i || !free_found) begin
          result_o.status = fbot_pkg::ST_BUSY;
        end else begin
          if (stop_pend_i) begin
            result_o.stop_issued = 1'b1;
            if (!item_i.engine_stop_ok) begin
              result_o.status = fbot_pkg::ST_ENGINE;
            end else begin
              stop_pend_o = 1'b0;
            end
          end
          if (result_o.status == fbot_pkg::ST_OK) begin
            if (!item_i.engine_start_ok) begin
              result_o.status = fbot_pkg::ST_ENGINE;
            end else begin
              owner_o[pick]       = fbot_pkg::OWN_CAPTURING;
              cap_vld_o           = 1'b1;
              cap_idx_o           = pick;
              stop_pend_o         = 1'b1;
              result_o.slot       = fbot_pkg::SlotFieldW'(pick);
              result_o.slot_valid = 1'b1;
            end
          end
        end
      end
      fbot_pkg::CMD_FRAME_DONE: begin
        if (!cap_vld_i || owner_i[cap_idx_i] != fbot_pkg::OWN_CAPTURING) begin
          result_o.error_inc = 1'b1;
          result_o.event_res = fbot_pkg::EV_ERROR;
        end else begin
          owner_o[cap_idx_i] = fbot_pkg::OWN_READY;
          rdy_vld_o          = 1'b1;
          rdy_idx_o          = cap_idx_i;
          cap_vld_o          = 1'b0;
          result_o.event_res = fbot_pkg::EV_READY;
        end
      end
      fbot_pkg::CMD_OVERRUN: begin
        if (cap_vld_i) begin
          owner_o[cap_idx_i] = fbot_pkg::OWN_FREE;
          cap_vld_o          = 1'b0;
        end
        result_o.overrun_inc = 1'b1;
        result_o.event_res   = fbot_pkg::EV_OVERRUN;
      end
      fbot_pkg::CMD_ENGINE_ERROR: begin
        if (cap_vld_i) begin
          owner_o[cap_idx_i] = fbot_pkg::OWN_FREE;
          cap_vld_o          = 1'b0;
        end
        result_o.error_inc = 1'b1;
        result_o.event_res = fbot_pkg::EV_ERROR;
      end
      fbot_pkg::CMD_STOP: begin
        if (!enabled_i) begin
          result_o.status = fbot_pkg::ST_NOT_INIT;
        end else begin
          if (stop_pend_i) begin
            result_o.stop_issued = 1'b1;
            if (!item_i.engine_stop_ok) begin
              result_o.status = fbot_pkg::ST_ENGINE;
            end else begin
              stop_pend_o = 1'b0;
            end
          end
          if (result_o.status == fbot_pkg::ST_OK && cap_vld_i) begin
            owner_o[cap_idx_i] = fbot_pkg::OWN_FREE;
            cap_vld_o          = 1'b0;
          end
        end
      end
      fbot_pkg::CMD_ACQUIRE: begin
        if (!enabled_i) begin
          result_o.status = fbot_pkg::ST_NOT_INIT;
        end else if (!rdy_vld_i || owner_i[rdy_idx_i] != fbot_pkg::OWN_READY) begin
          result_o.status = fbot_pkg::ST_BUSY;
        end else begin
          owner_o[rdy_idx_i]  = fbot_pkg::OWN_IN_USE;
          rdy_vld_o           = 1'b0;
          result_o.slot       = fbot_pkg::SlotFieldW'(rdy_idx_i);
          result_o.slot_valid = 1'b1;
        end
      end
      fbot_pkg::CMD_RELEASE: begin
        if (item_i.release_null || !rel_in_range) begin
          result_o.status = fbot_pkg::ST_PARAM;
        end else if (owner_i[rel_idx] != fbot_pkg::OWN_IN_USE) begin
          result_o.status = fbot_pkg::ST_BUSY;
        end else begin
          owner_o[rel_idx] = fbot_pkg::OWN_FREE;
        end
      end
      default: begin
        result_o.status = fbot_pkg::ST_PARAM;
      end
    endcase
  end

endmodule
